// File: rtl/byte_budget_lru_cache_top_assert.svh
// assertion macros for the byte budget lru cache checker
// depends on nothing; expects clk and arst_n in the scope of each use
`ifndef BYTE_BUDGET_LRU_CACHE_TOP_ASSERT_SVH
`define BYTE_BUDGET_LRU_CACHE_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define BBLC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define BBLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bblc_pkg.sv
// shared types and constants of the byte budget lru cache
// used by the top level and its checker; depends on nothing
package bblc_pkg;
	localparam int MAX_ENTRIES = 16;

	localparam int KEY_W    = 32;
	localparam int LEN_W    = 24;
	localparam int CAP_W    = 24;
	localparam int OVH_W    = 8;
	localparam int USED_W   = 25;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;

	localparam logic [STATUS_W-1:0] STATUS_HIT      = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_REJECTED = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_EVICTED  = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_FLUSHED  = 3'd4;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_OVERHEAD = 1'b1;

	localparam logic [OVH_W-1:0] OVERHEAD_RESET = 8'd24;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_EVICT,
		ST_INSERT
	} seq_state_t;
endpackage

// File: rtl/byte_budget_lru_cache_top.sv
// byte budget lru cache bookkeeping: slot table, recency ranks and eviction sequencer
// depends on bblc_pkg
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------------------
//  request   | start / busy              | action, flash_address, request_length
//  result    | result_strobe (no stall)  | status, entry_key, slot, entry_length, last_of_run
//  config    | cfg_we                    | cfg_index, cfg_wdata
//
// a flush is done straight from idle; a hit or reject passes capture, then parallel lookup
// a miss passes capture, lookup, the evictions one at a time through the single victim
// path, a check that sees the budget met, then insert
// results come from the result register, at most one per cycle; the receiver cannot stall
// arst_n clears the valid bits, byte count, entry count and registers to reset values
module byte_budget_lru_cache_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            action,
	input  logic [bblc_pkg::KEY_W-1:0]      flash_address,
	input  logic [bblc_pkg::LEN_W-1:0]      request_length,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [bblc_pkg::CAP_W-1:0]      cfg_wdata,
	output logic                            result_strobe,
	output logic [bblc_pkg::STATUS_W-1:0]   status,
	output logic [bblc_pkg::KEY_W-1:0]      entry_key,
	output logic [bblc_pkg::SLOT_W-1:0]     slot,
	output logic [bblc_pkg::LEN_W-1:0]      entry_length,
	output logic                            last_of_run
);
	import bblc_pkg::*;

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	// sequencer and configuration
	seq_state_t        state_q, state_d;
	logic [CAP_W-1:0]  capacity_q;
	logic [OVH_W-1:0]  overhead_q;

	// slot table
	logic              valid_q [MAX_ENTRIES];
	logic [KEY_W-1:0]  key_q   [MAX_ENTRIES];
	logic [LEN_W-1:0]  len_q   [MAX_ENTRIES];
	logic [IW-1:0]     rank_q  [MAX_ENTRIES];
	logic [CW-1:0]     count_q;
	logic [USED_W-1:0] used_q;

	// captured request
	logic [KEY_W-1:0]  req_key_q;
	logic [LEN_W-1:0]  req_len_q;

	// result register
	logic                strobe_q;
	logic [STATUS_W-1:0] status_q;
	logic [KEY_W-1:0]    ekey_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [LEN_W-1:0]    elen_q;
	logic                last_q;

	// lookup and victim search
	logic [MAX_ENTRIES-1:0] hit_vec, lru_vec;
	logic [IW-1:0]          hit_idx, lru_idx, free_idx;
	logic                   hit_any, any_valid, free_any;
	logic [CW-1:0]          cnt_m1;
	logic [USED_W-1:0]      needed, charge;
	logic [USED_W:0]        total;
	logic                   reject, over, full, evict_go;

	// actions chosen by the output decode
	logic                do_flush, do_hit, do_evict, do_insert, emit;
	logic [STATUS_W-1:0] st_d;
	logic [KEY_W-1:0]    ekey_d;
	logic [IW-1:0]       idx_d;
	logic [LEN_W-1:0]    elen_d;
	logic                last_d;

	// ranks of valid slots are 0..count-1, so the lru entry is the one ranked count-1
	assign cnt_m1 = count_q - CW'(1);

	always_comb begin
		hit_idx  = '0;
		lru_idx  = '0;
		free_idx = '0;
		free_any = 1'b0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == req_key_q);
			lru_vec[i] = valid_q[i] && (CW'(rank_q[i]) == cnt_m1);
			if (hit_vec[i]) hit_idx = hit_idx | IW'(i);
			if (lru_vec[i]) lru_idx = lru_idx | IW'(i);
		end
		// lowest free slot wins
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IW'(i);
				free_any = 1'b1;
			end
		end
	end

	assign hit_any   = |hit_vec;
	assign any_valid = |lru_vec;
	assign needed    = USED_W'(req_len_q) + USED_W'(overhead_q);
	assign reject    = (req_len_q == '0) || (needed > USED_W'(capacity_q));
	assign total     = (USED_W+1)'(used_q) + (USED_W+1)'(needed);
	assign over      = total > (USED_W+1)'(capacity_q);
	assign full      = !free_any;
	// keep evicting while over budget, and once more if the table is still full
	assign evict_go  = any_valid && (over || full);
	assign charge    = USED_W'(len_q[lru_idx]) + USED_W'(overhead_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && action == ACT_READ) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				if (hit_any || reject) state_d = ST_IDLE;
				else state_d = ST_EVICT;
			end
			ST_EVICT: begin
				if (!evict_go) state_d = ST_INSERT;
			end
			ST_INSERT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// actions and result fields
	always_comb begin
		do_flush  = 1'b0;
		do_hit    = 1'b0;
		do_evict  = 1'b0;
		do_insert = 1'b0;
		emit      = 1'b0;
		st_d      = STATUS_HIT;
		ekey_d    = req_key_q;
		idx_d     = '0;
		elen_d    = req_len_q;
		last_d    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (start && action == ACT_FLUSH) begin
					do_flush = 1'b1;
					emit     = 1'b1;
					st_d     = STATUS_FLUSHED;
					ekey_d   = '0;
					elen_d   = '0;
				end
			end
			ST_LOOK: begin
				if (hit_any) begin
					do_hit = 1'b1;
					emit   = 1'b1;
					st_d   = STATUS_HIT;
					idx_d  = hit_idx;
					elen_d = len_q[hit_idx];
				end else if (reject) begin
					emit = 1'b1;
					st_d = STATUS_REJECTED;
				end
			end
			ST_EVICT: begin
				if (evict_go) begin
					do_evict = 1'b1;
					emit     = 1'b1;
					st_d     = STATUS_EVICTED;
					ekey_d   = key_q[lru_idx];
					idx_d    = lru_idx;
					elen_d   = len_q[lru_idx];
					last_d   = 1'b0;
				end
			end
			ST_INSERT: begin
				do_insert = 1'b1;
				emit      = 1'b1;
				st_d      = STATUS_INSERTED;
				idx_d     = free_idx;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			capacity_q <= '0;
			overhead_q <= OVERHEAD_RESET;
			count_q    <= '0;
			used_q     <= '0;
			strobe_q   <= 1'b0;
			for (int i = 0; i < MAX_ENTRIES; i++) valid_q[i] <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (cfg_we) begin
				if (cfg_index == REG_CAPACITY) capacity_q <= cfg_wdata;
				if (cfg_index == REG_OVERHEAD) overhead_q <= cfg_wdata[OVH_W-1:0];
			end
			if (do_flush) begin
				count_q <= '0;
				used_q  <= '0;
				for (int i = 0; i < MAX_ENTRIES; i++) valid_q[i] <= 1'b0;
			end
			if (do_evict) begin
				valid_q[lru_idx] <= 1'b0;
				count_q          <= count_q - CW'(1);
				// saturate at zero, overhead may have been raised
				used_q           <= (used_q >= charge) ? used_q - charge : '0;
			end
			if (do_insert) begin
				valid_q[free_idx] <= 1'b1;
				count_q           <= count_q + CW'(1);
				used_q            <= used_q + needed;
			end
		end
	end

	// payload: request capture, slot contents, ranks, result register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_key_q <= flash_address;
			req_len_q <= request_length;
		end
		if (do_hit) begin
			// entries more recent than the hit age by one
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				if (valid_q[j] && rank_q[j] < rank_q[hit_idx]) rank_q[j] <= rank_q[j] + IW'(1);
			end
			rank_q[hit_idx] <= '0;
		end
		if (do_insert) begin
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				if (valid_q[j]) rank_q[j] <= rank_q[j] + IW'(1);
			end
			rank_q[free_idx] <= '0;
			key_q[free_idx]  <= req_key_q;
			len_q[free_idx]  <= req_len_q;
		end
		status_q <= st_d;
		ekey_q   <= ekey_d;
		slot_q   <= SLOT_W'(idx_d);
		elen_q   <= elen_d;
		last_q   <= last_d;
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign status        = status_q;
	assign entry_key     = ekey_q;
	assign slot          = slot_q;
	assign entry_length  = elen_q;
	assign last_of_run   = last_q;
endmodule

// File: rtl/bblc_checker.sv
// port level checker for the byte budget lru cache, bound to the top level
// depends on bblc_pkg and byte_budget_lru_cache_top_assert.svh
`include "byte_budget_lru_cache_top_assert.svh"

module bblc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          action,
	input logic                          result_strobe,
	input logic [bblc_pkg::STATUS_W-1:0] status,
	input logic                          last_of_run
);
	import bblc_pkg::*;

	`BBLC_ASSERT_NEXT(a_run_continues, result_strobe && !last_of_run, busy, "run ended without a final result")
	`BBLC_ASSERT_SAME(a_evict_not_last, result_strobe && status == STATUS_EVICTED, !last_of_run, "eviction marked last")
	`BBLC_ASSERT_NEXT(a_read_busy, start && !busy && action == ACT_READ, busy, "read transfer did not raise busy")
	`BBLC_ASSERT_NEXT(a_flush_result, start && !busy && action == ACT_FLUSH, result_strobe && status == STATUS_FLUSHED && last_of_run, "flush gave no result")
	`BBLC_ASSERT_SAME(a_mid_run_busy, result_strobe && !last_of_run, busy, "not busy inside a run")
endmodule

bind byte_budget_lru_cache_top bblc_checker u_bblc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.action        (action),
	.result_strobe (result_strobe),
	.status        (status),
	.last_of_run   (last_of_run)
);

// File: dv/tb_byte_budget_lru_cache_top.sv
// self-checking testbench of the byte budget lru cache bookkeeping block
// depends on bblc_pkg and byte_budget_lru_cache_top; holds its own lru predictor
`timescale 1ns / 100ps

module tb_byte_budget_lru_cache_top;
	import bblc_pkg::*;

	localparam int NSLOT    = 16;
	localparam int WD_LIMIT = 4000;

	typedef struct packed {
		logic [STATUS_W-1:0] st;
		logic [KEY_W-1:0]    key;
		logic [SLOT_W-1:0]   sl;
		logic [LEN_W-1:0]    len;
		logic                last;
	} cache_event_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                action;
	logic [KEY_W-1:0]    flash_address;
	logic [LEN_W-1:0]    request_length;
	logic                cfg_we;
	logic                cfg_index;
	logic [CAP_W-1:0]    cfg_wdata;
	logic                result_strobe;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    entry_key;
	logic [SLOT_W-1:0]   slot;
	logic [LEN_W-1:0]    entry_length;
	logic                last_of_run;

	byte_budget_lru_cache_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .flash_address(flash_address),
		.request_length(request_length), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .result_strobe(result_strobe), .status(status),
		.entry_key(entry_key), .slot(slot), .entry_length(entry_length),
		.last_of_run(last_of_run)
	);

	// predictor state: a private copy of the slot table and registers
	logic [CAP_W-1:0]  cap_q;
	logic [OVH_W-1:0]  ovh_q;
	logic              pv[NSLOT];
	logic [KEY_W-1:0]  pk[NSLOT];
	logic [LEN_W-1:0]  pl[NSLOT];
	int unsigned       pr[NSLOT];
	longint unsigned   used_q;

	cache_event_t pending_events[$];
	int   error_count;
	int   idle_cycles;
	bit   allow_gaps;
	// recent keys, replayed to produce hits
	logic [KEY_W-1:0] key_pool[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic int lru_victim();
		int best = -1;
		for (int i = 0; i < NSLOT; i++)
			if (pv[i] && (best < 0 || pr[i] > pr[best]))
				best = i;
		return best;
	endfunction

	function automatic void evict_lru();
		int v = lru_victim();
		longint unsigned charge;
		if (v < 0)
			return;
		pv[v] = 1'b0;
		charge = longint'(pl[v]) + ovh_q;
		used_q = (used_q >= charge) ? used_q - charge : 0;
		pending_events.push_back({STATUS_EVICTED, pk[v], SLOT_W'(v), pl[v], 1'b0});
	endfunction

	function automatic int lowest_free();
		for (int i = 0; i < NSLOT; i++)
			if (!pv[i])
				return i;
		return -1;
	endfunction

	// expected results of one accepted request, appended in order
	function automatic void predict_lookup(input logic act, input logic [KEY_W-1:0] addr,
			input logic [LEN_W-1:0] len);
		longint unsigned needed;
		int fs;
		if (act == ACT_FLUSH) begin
			for (int i = 0; i < NSLOT; i++)
				pv[i] = 1'b0;
			used_q = 0;
			pending_events.push_back({STATUS_FLUSHED, 32'd0, 4'd0, 24'd0, 1'b1});
			return;
		end
		for (int i = 0; i < NSLOT; i++) begin
			if (pv[i] && pk[i] == addr) begin
				for (int j = 0; j < NSLOT; j++)
					if (pv[j] && pr[j] < pr[i])
						pr[j]++;
				pr[i] = 0;
				pending_events.push_back({STATUS_HIT, addr, SLOT_W'(i), pl[i], 1'b1});
				return;
			end
		end
		needed = longint'(len) + ovh_q;
		if (len == 0 || needed > cap_q) begin
			pending_events.push_back({STATUS_REJECTED, addr, 4'd0, len, 1'b1});
			return;
		end
		while (used_q + needed > cap_q && lru_victim() >= 0)
			evict_lru();
		fs = lowest_free();
		if (fs < 0) begin
			evict_lru();
			fs = lowest_free();
			if (fs < 0)
				fs = 0;
		end
		for (int j = 0; j < NSLOT; j++)
			if (pv[j])
				pr[j]++;
		pv[fs] = 1'b1;
		pk[fs] = addr;
		pl[fs] = len;
		pr[fs] = 0;
		used_q += needed;
		pending_events.push_back({STATUS_INSERTED, addr, SLOT_W'(fs), len, 1'b1});
	endfunction

	// result checker: every strobe is one transfer, compared with the oldest expectation
	always @(posedge clk) begin
		cache_event_t got, exp_ev;
		if (arst_n && result_strobe) begin
			got = {status, entry_key, slot, entry_length, last_of_run};
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", got));
			end else begin
				exp_ev = pending_events.pop_front();
				if (got.st !== exp_ev.st)
					report_mismatch($sformatf("status %0d want %0d", got.st, exp_ev.st));
				if (got.key !== exp_ev.key)
					report_mismatch($sformatf("key %h want %h", got.key, exp_ev.key));
				if (got.sl !== exp_ev.sl)
					report_mismatch($sformatf("slot %0d want %0d", got.sl, exp_ev.sl));
				if (got.len !== exp_ev.len)
					report_mismatch($sformatf("length %h want %h", got.len, exp_ev.len));
				if (got.last !== exp_ev.last)
					report_mismatch($sformatf("last %b want %b", got.last, exp_ev.last));
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || result_strobe || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// send one request; start stays high until the transfer edge and is lowered
	// by the next gap or by the drain
	task automatic send_request(input logic act, input logic [KEY_W-1:0] addr,
			input logic [LEN_W-1:0] len);
		if (allow_gaps && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 11)) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start          <= 1'b1;
		action         <= act;
		flash_address  <= addr;
		request_length <= len;
		do
			@(posedge clk);
		while (busy);
		predict_lookup(act, addr, len);
		if (act == ACT_READ && len != 0) begin
			key_pool.push_back(addr);
			if (key_pool.size() > 24)
				void'(key_pool.pop_front());
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic write_reg(input logic idx, input logic [CAP_W-1:0] val);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CAPACITY)
			cap_q = val;
		else
			ovh_q = val[OVH_W-1:0];
	endtask

	task automatic read_req(input logic [KEY_W-1:0] addr, input logic [LEN_W-1:0] len);
		send_request(ACT_READ, addr, len);
	endtask

	task automatic flush_req();
		send_request(ACT_FLUSH, $urandom, LEN_W'($urandom));
	endtask

	// zero capacity after reset rejects everything
	task automatic test_reset_rejects();
		read_req(32'h0000_0000, 24'd1);
		read_req(32'hFFFF_FFFF, 24'hFF_FFFF);
		read_req(32'h1234_5678, 24'd0);
		flush_req();
	endtask

	// hits, misses, zero length, oversize, evictions by bytes and by slot count
	task automatic test_directed();
		write_reg(REG_CAPACITY, 24'd1000);
		write_reg(REG_OVERHEAD, 24'd0);
		read_req(32'hFFFF_FFFF, 24'd100);
		read_req(32'h0000_0000, 24'd200);
		read_req(32'hFFFF_FFFF, 24'd5);        // hit, length ignored
		read_req(32'hAAAA_5555, 24'd0);        // zero length miss
		read_req(32'h5555_AAAA, 24'd1001);     // too large
		read_req(32'h5555_AAAA, 24'd1000);     // evicts both
		read_req(32'h0000_0000, 24'd200);
		write_reg(REG_OVERHEAD, 24'd255);
		read_req(32'h0000_0001, 24'd745);      // exactly fits only alone
		flush_req();
		write_reg(REG_CAPACITY, 24'hFF_FFFF);
		write_reg(REG_OVERHEAD, 24'd1);
		for (int i = 0; i < 17; i++)
			read_req(32'h100 + i, 24'd1);      // seventeenth fills past all slots
		write_reg(REG_CAPACITY, 24'd10);       // lowered: next miss evicts down
		read_req(32'h9999, 24'd8);
		read_req(32'h9999, 24'd8);
		flush_req();
	endtask

	// random traffic under a sweep of register settings
	task automatic test_random(input int items);
		logic [KEY_W-1:0] addr;
		logic [LEN_W-1:0] len;
		int pick;
		for (int n = 0; n < items; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(0, 3))
					0: write_reg(REG_CAPACITY, 24'hFF_FFFF);
					1: write_reg(REG_CAPACITY, 24'd0);
					default: write_reg(REG_CAPACITY, CAP_W'($urandom_range(64, 4000)));
				endcase
				write_reg(REG_OVERHEAD, $urandom_range(0, 1) ? 24'($urandom_range(0, 255))
					: ($urandom_range(0, 1) ? 24'd255 : 24'd0));
			end
			if (n > items - 60)
				allow_gaps = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 45 && key_pool.size() != 0)
				addr = key_pool[$urandom_range(0, key_pool.size() - 1)];
			else
				addr = $urandom;
			if (pick % 10 == 0)
				len = LEN_W'($urandom);     // wide lengths, mostly rejected
			else if (pick % 10 == 1)
				len = '0;
			else
				len = LEN_W'($urandom_range(1, 600));
			if (pick == 99)
				flush_req();
			else
				read_req(addr, len);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		action         = ACT_READ;
		flash_address  = '0;
		request_length = '0;
		cfg_we         = 1'b0;
		cfg_index      = REG_CAPACITY;
		cfg_wdata      = '0;
		error_count    = 0;
		idle_cycles    = 0;
		allow_gaps     = 1'b1;
		cap_q          = '0;
		ovh_q          = OVERHEAD_RESET;
		used_q         = 0;
		for (int i = 0; i < NSLOT; i++) begin
			pv[i] = 1'b0;
			pk[i] = '0;
			pl[i] = '0;
			pr[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_rejects();
		test_directed();
		test_random(480);
		drain_results();
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
